FILE: rtl/core/tmsn_pkg.sv
// shared constants and types for the trimmed mean smoothing unit
`timescale 1ns / 1ps
package tmsn_pkg;
   localparam int CHANNELS_DEF      = 16;
   localparam int HISTORY_DEPTH_DEF = 6;
   localparam int BURST_LEN   = 10;
   localparam int SAMPLE_W    = 10;
   localparam int CH_W        = 4;
   localparam int TRIM_W      = 12;
   localparam int SUM_OUT_W   = 15;
   localparam int LEVEL_W     = 14;
   localparam int FLOOR_W     = 8;
   localparam int RANGE_W     = 10;
   localparam int CSR_W       = 10;
   localparam int CSR_IDX_W   = 1;
   localparam logic [CSR_IDX_W-1:0] REG_FLOOR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE = 1'd1;
   localparam int FULL_SCALE  = 250;
   localparam int FLOOR_MAX   = 249;
   localparam int QUEUE_DEPTH = 2;

   typedef logic [SAMPLE_W-1:0] sample_type;

   // classified word handed from front to back
   typedef struct packed {
      logic [CH_W-1:0]   channel;
      logic              in_range;
      logic [TRIM_W-1:0] trim;
   } job_type;
endpackage

FILE: rtl/core/tmsn_front.sv
// front end: accepts a burst, sorts it over cycles, forms the trimmed sum
`timescale 1ns / 1ps
module tmsn_front #(
   parameter int CHANNELS = tmsn_pkg::CHANNELS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic [tmsn_pkg::CH_W-1:0]             in_channel,
   input  tmsn_pkg::sample_type [tmsn_pkg::BURST_LEN-1:0] in_samples,
   output logic                                  job_valid,
   input  logic                                  job_ready,
   output tmsn_pkg::job_type                     job
);
   import tmsn_pkg::*;

   localparam int PASS_W = $clog2(BURST_LEN + 1);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SORT = 2'd1;
   localparam logic [1:0] S_SUM  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   sample_type [BURST_LEN-1:0] v_ff, v_in;
   logic [CH_W-1:0] ch_ff, ch_in;
   logic [TRIM_W-1:0] trim_ff, trim_in;
   sample_type [BURST_LEN-1:0] sorted;

   // one odd-even transposition pass per cycle
   always_comb begin
      sorted = v_ff;
      for (int i = 0; i + 1 < BURST_LEN; i++) begin
         if ((i % 2) == int'(pass_ff[0])) begin
            if (sorted[i] > sorted[i+1]) begin
               sorted[i]   = v_ff[i+1];
               sorted[i+1] = v_ff[i];
            end
         end
      end
   end

   assign in_ready  = (state_ff == S_IDLE);
   assign job_valid = (state_ff == S_OUT);
   assign job.channel  = ch_ff;
   assign job.in_range = (32'(ch_ff) < CHANNELS);
   assign job.trim     = trim_ff;

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      v_in     = v_ff;
      ch_in    = ch_ff;
      trim_in  = trim_ff;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               v_in     = in_samples;
               ch_in    = in_channel;
               pass_in  = '0;
               state_in = S_SORT;
            end
         end
         S_SORT: begin
            v_in    = sorted;
            pass_in = pass_ff + 1'b1;
            if (pass_ff == PASS_W'(BURST_LEN - 1)) state_in = S_SUM;
         end
         S_SUM: begin
            trim_in = TRIM_W'(v_ff[3]) + TRIM_W'(v_ff[4]) + TRIM_W'(v_ff[5])
                      + TRIM_W'(v_ff[6]);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (job_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
      v_ff    <= v_in;
      ch_ff   <= ch_in;
      trim_ff <= trim_in;
   end
endmodule

FILE: rtl/core/tmsn_queue.sv
// short word queue between front and back
`timescale 1ns / 1ps
module tmsn_queue #(
   parameter int DEPTH = tmsn_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  tmsn_pkg::job_type wr_data,
   output logic              rd_valid,
   input  logic              rd_ready,
   output tmsn_pkg::job_type rd_data
);
   import tmsn_pkg::*;
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type mem_ff [DEPTH];
   logic [PW-1:0] wp_ff, rp_ff;
   logic [CW-1:0] cnt_ff;
   logic do_wr, do_rd;

   assign wr_ready = (cnt_ff != CW'(DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = mem_ff[rp_ff];
   assign do_wr = wr_valid && wr_ready;
   assign do_rd = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (do_wr) wp_ff <= (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         if (do_rd) rp_ff <= (rp_ff == PW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + CW'(do_wr) - CW'(do_rd);
      end
      if (do_wr) mem_ff[wp_ff] <= wr_data;
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH)) else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (do_wr && !do_rd) |=> rd_valid) else $error("queue lost a word");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> !do_rd) else $error("queue read while empty");
endmodule

FILE: rtl/core/tmsn_back.sv
// back end: history update, history sum, scaling divide, clamp, result register
`timescale 1ns / 1ps
module tmsn_back #(
   parameter int CHANNELS      = tmsn_pkg::CHANNELS_DEF,
   parameter int HISTORY_DEPTH = tmsn_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             job_valid,
   output logic                             job_ready,
   input  tmsn_pkg::job_type                job,
   input  logic [tmsn_pkg::FLOOR_W-1:0]     floor_level,
   input  logic [tmsn_pkg::RANGE_W-1:0]     range_out,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [tmsn_pkg::CH_W-1:0]        out_channel,
   output logic [tmsn_pkg::SUM_OUT_W-1:0]   out_sum,
   output logic [tmsn_pkg::LEVEL_W-1:0]     out_level
);
   import tmsn_pkg::*;

   localparam int ENTRIES = CHANNELS * HISTORY_DEPTH;
   localparam int AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int KW  = $clog2(HISTORY_DEPTH + 1);
   localparam int SW  = TRIM_W + $clog2(HISTORY_DEPTH + 1);   // full history sum
   localparam int BW  = SW;                                    // 4*D*F fits in SW
   localparam int NUMW = SW + RANGE_W + 2;                    // 4*R*N
   localparam int DENW = 8 + $clog2(HISTORY_DEPTH + 1);       // D*(250-F)
   localparam int QW   = NUMW;
   localparam int DCW  = $clog2(NUMW + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD    = 4'd1;
   localparam logic [3:0] S_ACC   = 4'd2;
   localparam logic [3:0] S_PREP  = 4'd3;
   localparam logic [3:0] S_MUL   = 4'd4;
   localparam logic [3:0] S_DIV   = 4'd5;
   localparam logic [3:0] S_CLAMP = 4'd6;
   localparam logic [3:0] S_OUT   = 4'd7;
   localparam logic [3:0] S_CLEAR = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [TRIM_W-1:0] hist_mem [ENTRIES];
   logic [TRIM_W-1:0] rd_ff;
   logic [AW-1:0] clr_ff;
   logic [KW-1:0] k_ff;
   logic [AW-1:0] row_ff;
   job_type job_ff;
   logic [SW-1:0] sum_ff;
   logic [7:0] f_ff;
   logic [RANGE_W-1:0] r_ff;
   logic [NUMW-1:0] rem_ff, num_ff;
   logic [DENW-1:0] den_ff;
   logic [DCW-1:0] dcnt_ff;
   logic neg_ff;
   logic [SUM_OUT_W-1:0] osum_ff;
   logic [LEVEL_W-1:0] olev_ff;
   logic [CH_W-1:0] och_ff;

   // memory access signals
   logic [AW-1:0] rd_addr, wr_addr;
   logic rd_en, wr_en;
   logic [TRIM_W-1:0] wr_data;
   logic [KW-1:0] k_src;

   // history of a row read oldest first; entry k gets entry k+1, last gets trim
   assign k_src   = k_ff + 1'b1;
   assign rd_addr = row_ff + AW'(k_src);
   assign rd_en   = (state_ff == S_RD) && (32'(k_src) < HISTORY_DEPTH);
   assign wr_addr = (state_ff == S_CLEAR) ? clr_ff : row_ff + AW'(k_ff);
   assign wr_en   = (state_ff == S_CLEAR) ||
                    ((state_ff == S_ACC) && job_ff.in_range);
   assign wr_data = (state_ff == S_CLEAR) ? '0 :
                    (32'(k_ff) == HISTORY_DEPTH - 1) ? job_ff.trim : rd_ff;

   always_ff @(posedge clock) begin
      if (rd_en) rd_ff <= hist_mem[rd_addr];
      if (wr_en) hist_mem[wr_addr] <= wr_data;
   end

   logic [NUMW-1:0] rem_sh;
   logic rem_ge;
   assign rem_sh = {rem_ff[NUMW-2:0], num_ff[NUMW-1]};
   assign rem_ge = ({1'b0, rem_sh} >= (NUMW+1)'(den_ff));

   logic [QW-1:0] hi, lo;
   assign hi = QW'({r_ff, 4'b0});
   assign lo = QW'({f_ff, 4'b0});

   assign job_ready   = (state_ff == S_IDLE);
   assign out_valid   = (state_ff == S_OUT);
   assign out_channel = och_ff;
   assign out_sum     = osum_ff;
   assign out_level   = olev_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_ff == AW'(ENTRIES - 1)) state_in = S_IDLE;
         S_IDLE:  if (job_valid) state_in = S_RD;
         S_RD:    state_in = S_ACC;
         S_ACC:   state_in = (32'(k_ff) == HISTORY_DEPTH - 1) ? S_PREP : S_RD;
         S_PREP:  state_in = S_MUL;
         S_MUL:   state_in = S_DIV;
         S_DIV:   if (dcnt_ff == DCW'(NUMW - 1)) state_in = S_CLAMP;
         S_CLAMP: state_in = S_OUT;
         S_OUT:   if (out_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + 1'b1;
      end
      case (state_ff)
         S_IDLE: begin
            job_ff <= job;
            k_ff   <= '0;
            sum_ff <= '0;
            row_ff <= AW'(32'(job.channel) * HISTORY_DEPTH);
            f_ff   <= (floor_level > 8'(FLOOR_MAX)) ? 8'(FLOOR_MAX) : floor_level;
            r_ff   <= range_out;
         end
         S_ACC: begin
            if (job_ff.in_range) sum_ff <= sum_ff + SW'(wr_data);
            k_ff <= k_ff + 1'b1;
         end
         S_PREP: begin
            // N = S - 4*D*F, den = D*(250-F)
            neg_ff <= (sum_ff < BW'(32'(f_ff) * 4 * HISTORY_DEPTH));
            num_ff <= NUMW'(sum_ff - BW'(32'(f_ff) * 4 * HISTORY_DEPTH));
            den_ff <= DENW'((FULL_SCALE - 32'(f_ff)) * HISTORY_DEPTH);
         end
         S_MUL: begin
            num_ff  <= neg_ff ? '0 : NUMW'(num_ff * NUMW'({r_ff, 2'b0}));
            rem_ff  <= '0;
            dcnt_ff <= '0;
         end
         S_DIV: begin
            // restoring divide, one quotient bit a cycle
            rem_ff  <= rem_ge ? rem_sh - NUMW'(den_ff) : rem_sh;
            num_ff  <= {num_ff[NUMW-2:0], rem_ge};
            dcnt_ff <= dcnt_ff + 1'b1;
         end
         default: ;
      endcase
      if (state_ff == S_CLAMP) begin
         och_ff  <= job_ff.channel;
         osum_ff <= SUM_OUT_W'(sum_ff);
         if (num_ff >= hi)
            olev_ff <= (hi < lo) ? LEVEL_W'(lo) : LEVEL_W'(hi);
         else
            olev_ff <= (num_ff < lo) ? LEVEL_W'(lo) : LEVEL_W'(num_ff);
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !out_ready) |=> (state_ff == S_OUT && $stable(olev_ff)))
      else $error("result changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC && !job_ff.in_range) |-> !wr_en)
      else $error("history written for bad channel");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLAMP) |=> (state_ff == S_OUT))
      else $error("clamp did not lead to result");
endmodule

FILE: rtl/core/trimmed_mean_smooth_normalize_unit.sv
// top level of the trimmed mean smoothing and normalizing unit
`timescale 1ns / 1ps
// usage
//   req_ channel: push a word (channel plus ten samples) when full is low
//   rsp_ channel: while empty is low the oldest result is shown; pop takes it
//   csr_ port: write floor_level (index 0) or range_out (index 1) while idle
// steps and flow
//   front: accept cycle, 10 odd-even sort passes, a sum cycle and a handoff
//   cycle; it takes a new word only after handing the last one to a
//   two-entry queue
//   back: take cycle, a read step and an accumulate step per history entry, prepare,
//   multiply, a restoring divide at one bit a cycle (27 bits at default depth),
//   clamp and result; it takes a new word only after its result is popped
//   front and back overlap, so the sustained rate is set by the back end
// reset
//   registers return to floor 1, range 250; the history memory is cleared by
//   a pass over all CHANNELS*HISTORY_DEPTH entries (96 by default); words pushed
//   meanwhile wait in the front and the queue
// stall
//   a held result stalls the back end, the queue fills, then full rises
module trimmed_mean_smooth_normalize_unit #(
   parameter int CHANNELS      = tmsn_pkg::CHANNELS_DEF,
   parameter int HISTORY_DEPTH = tmsn_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            full,
   input  logic [tmsn_pkg::CH_W-1:0]       req_channel,
   input  logic [tmsn_pkg::SAMPLE_W-1:0]   req_sample_0,
   input  logic [tmsn_pkg::SAMPLE_W-1:0]   req_sample_1,
   input  logic [tmsn_pkg::SAMPLE_W-1:0]   req_sample_2,
   input  logic [tmsn_pkg::SAMPLE_W-1:0]   req_sample_3,
   input  logic [tmsn_pkg::SAMPLE_W-1:0]   req_sample_4,
   input  logic [tmsn_pkg::SAMPLE_W-1:0]   req_sample_5,
   input  logic [tmsn_pkg::SAMPLE_W-1:0]   req_sample_6,
   input  logic [tmsn_pkg::SAMPLE_W-1:0]   req_sample_7,
   input  logic [tmsn_pkg::SAMPLE_W-1:0]   req_sample_8,
   input  logic [tmsn_pkg::SAMPLE_W-1:0]   req_sample_9,
   output logic                            empty,
   input  logic                            rsp_pop,
   output logic [tmsn_pkg::CH_W-1:0]       rsp_channel_out,
   output logic [tmsn_pkg::SUM_OUT_W-1:0]  rsp_smoothed_sum,
   output logic [tmsn_pkg::LEVEL_W-1:0]    rsp_level,
   input  logic                            csr_write,
   input  logic [tmsn_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tmsn_pkg::CSR_W-1:0]      csr_data
);
   import tmsn_pkg::*;

   logic [FLOOR_W-1:0] floor_ff;
   logic [RANGE_W-1:0] range_ff;
   sample_type [BURST_LEN-1:0] samples;
   logic in_ready, f_valid, f_ready, b_valid, b_ready, out_valid;
   job_type f_job, b_job;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= FLOOR_W'(1);
         range_ff <= RANGE_W'(FULL_SCALE);
      end else if (csr_write) begin
         case (csr_index)
            REG_FLOOR: floor_ff <= csr_data[FLOOR_W-1:0];
            REG_RANGE: range_ff <= csr_data[RANGE_W-1:0];
            default: ;
         endcase
      end
   end

   assign samples = {req_sample_9, req_sample_8, req_sample_7, req_sample_6,
                     req_sample_5, req_sample_4, req_sample_3, req_sample_2,
                     req_sample_1, req_sample_0};
   assign full  = !in_ready;
   assign empty = !out_valid;

   tmsn_front #(.CHANNELS(CHANNELS)) u_front (
      .clock, .reset,
      .in_valid(req_push), .in_ready,
      .in_channel(req_channel), .in_samples(samples),
      .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
   );

   tmsn_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
      .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job)
   );

   tmsn_back #(.CHANNELS(CHANNELS), .HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
      .clock, .reset,
      .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
      .floor_level(floor_ff), .range_out(range_ff),
      .out_valid, .out_ready(rsp_pop),
      .out_channel(rsp_channel_out), .out_sum(rsp_smoothed_sum),
      .out_level(rsp_level)
   );
endmodule

FILE: tb/trimmed_mean_smooth_normalize_unit_tb.sv
// testbench for the trimmed mean smoothing and normalizing unit
`timescale 1ns / 1ps
module trimmed_mean_smooth_normalize_unit_tb;
   import tmsn_pkg::*;

   localparam int NCH   = CHANNELS_DEF;
   localparam int DEPTH = HISTORY_DEPTH_DEF;

   // one expected result word
   typedef struct packed {
      logic [CH_W-1:0]      channel;
      logic [SUM_OUT_W-1:0] sum;
      logic [LEVEL_W-1:0]   level;
   } level_word_type;

   typedef sample_type burst_type [BURST_LEN];

   int errors = 0;

   // prints one line per mismatch and counts it
   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
   endtask

   // filter model: per-channel history, register copies and expected words
   class level_tracker;
      logic [TRIM_W-1:0] history [NCH][DEPTH];
      logic [FLOOR_W-1:0] floor_reg;
      logic [RANGE_W-1:0] range_reg;
      level_word_type pending [$];

      function new();
         foreach (history[c, k]) history[c][k] = '0;
         floor_reg = 8'd1;
         range_reg = 10'd250;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
         if (idx == REG_FLOOR) floor_reg = val[FLOOR_W-1:0];
         else range_reg = val[RANGE_W-1:0];
      endfunction

      // sort the burst and sum sorted positions 3..6
      function logic [TRIM_W-1:0] middle_four(burst_type b);
         int v [BURST_LEN];
         int t;
         foreach (b[i]) v[i] = int'(b[i]);
         for (int i = 0; i < BURST_LEN; i++)
            for (int j = 0; j < BURST_LEN - 1 - i; j++)
               if (v[j] > v[j+1]) begin
                  t = v[j]; v[j] = v[j+1]; v[j+1] = t;
               end
         return TRIM_W'(v[3] + v[4] + v[5] + v[6]);
      endfunction

      function logic [LEVEL_W-1:0] scale(longint s);
         longint f, r, base, q;
         f = (floor_reg > FLOOR_MAX) ? longint'(FLOOR_MAX) : longint'(floor_reg);
         r = longint'(range_reg);
         base = 4 * DEPTH * f;
         q = 0;
         if (s >= base) q = (4 * r * (s - base)) / (DEPTH * (FULL_SCALE - f));
         if (q >= 16 * r) q = 16 * r;
         if (q < 16 * f) q = 16 * f;
         return LEVEL_W'(q);
      endfunction

      function void note_input(logic [CH_W-1:0] ch, burst_type b);
         level_word_type w;
         longint s;
         s = 0;
         if (ch < NCH) begin
            for (int k = 0; k < DEPTH - 1; k++) history[ch][k] = history[ch][k+1];
            history[ch][DEPTH-1] = middle_four(b);
            for (int k = 0; k < DEPTH; k++) s += longint'(history[ch][k]);
         end
         w.channel = ch;
         w.sum = SUM_OUT_W'(s);
         w.level = scale(s);
         pending.push_back(w);
      endfunction

      task check_result(logic [CH_W-1:0] ch, logic [SUM_OUT_W-1:0] sum,
                        logic [LEVEL_W-1:0] lvl);
         level_word_type w;
         if (pending.size() == 0) begin
            report_mismatch("unexpected word, channel", int'(ch), -1);
            return;
         end
         w = pending.pop_front();
         if (ch !== w.channel) report_mismatch("channel_out", int'(ch), int'(w.channel));
         if (sum !== w.sum) report_mismatch("smoothed_sum", int'(sum), int'(w.sum));
         if (lvl !== w.level) report_mismatch("level", int'(lvl), int'(w.level));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_push = 0;
   logic full;
   logic [CH_W-1:0] req_channel = '0;
   sample_type req_sample [BURST_LEN];
   logic empty;
   logic rsp_pop = 0;
   logic [CH_W-1:0] rsp_channel_out;
   logic [SUM_OUT_W-1:0] rsp_smoothed_sum;
   logic [LEVEL_W-1:0] rsp_level;
   logic csr_write = 0;
   logic [CSR_IDX_W-1:0] csr_index = REG_FLOOR;
   logic [CSR_W-1:0] csr_data = '0;

   level_tracker tracker = new();
   bit hold_off = 0;        // long receiver stall requested by the stimulus

   initial foreach (req_sample[i]) req_sample[i] = '0;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   trimmed_mean_smooth_normalize_unit i_dut (
      .clock, .reset, .req_push, .full, .req_channel,
      .req_sample_0(req_sample[0]), .req_sample_1(req_sample[1]),
      .req_sample_2(req_sample[2]), .req_sample_3(req_sample[3]),
      .req_sample_4(req_sample[4]), .req_sample_5(req_sample[5]),
      .req_sample_6(req_sample[6]), .req_sample_7(req_sample[7]),
      .req_sample_8(req_sample[8]), .req_sample_9(req_sample[9]),
      .empty, .rsp_pop, .rsp_channel_out, .rsp_smoothed_sum, .rsp_level,
      .csr_write, .csr_index, .csr_data
   );

   // receiver: stalls in its own pattern, checks each popped word
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !empty)
            tracker.check_result(rsp_channel_out, rsp_smoothed_sum, rsp_level);
         if (hold_off) rsp_pop <= 1'b0;
         else case ($urandom_range(0, 3))
            0: rsp_pop <= ($urandom_range(0, 7) == 0);
            default: rsp_pop <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // offer one word and hold it until the block takes it
   task automatic push_word(input logic [CH_W-1:0] ch, input burst_type b);
      req_push <= 1'b1;
      req_channel <= ch;
      foreach (b[i]) req_sample[i] <= b[i];
      do @(posedge clock); while (full);
      tracker.note_input(ch, b);
   endtask

   task automatic idle_cycles(input int n);
      req_push <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // wait until every expected word has come, then let the back end settle
   task automatic drain();
      req_push <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_W'(val);
      @(posedge clock);
      csr_write <= 1'b0;
      tracker.write_reg(idx, CSR_W'(val));
      @(posedge clock);
   endtask

   // random burst; mode picks spread, clustered, extreme or low values
   function automatic burst_type rand_burst();
      burst_type b;
      int mode, base;
      mode = $urandom_range(0, 3);
      base = $urandom_range(0, 1023);
      foreach (b[i])
         case (mode)
            0: b[i] = sample_type'($urandom_range(0, 1023));
            1: b[i] = sample_type'((base + $urandom_range(0, 40)) % 1024);
            2: b[i] = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
            default: b[i] = sample_type'($urandom_range(0, 255));
         endcase
      return b;
   endfunction

   function automatic burst_type flat_burst(input int v);
      burst_type b;
      foreach (b[i]) b[i] = sample_type'(v);
      return b;
   endfunction

   // random traffic in bursts with gaps
   task automatic random_words(input int n);
      int left;
      left = n;
      while (left > 0) begin
         if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 60));
         repeat ($urandom_range(1, 12)) begin
            if (left > 0) begin
               push_word(CH_W'($urandom_range(0, 15)), rand_burst());
               left--;
            end
         end
      end
   endtask

   initial begin
      int floors [6] = '{1, 0, 249, 200, 255, 37};
      int ranges [6] = '{250, 1023, 1, 100, 1023, 0};
      burst_type b;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, sorted and reversed bursts, full history fill
      push_word(4'd0, flat_burst(0));
      push_word(4'd15, flat_burst(1023));
      foreach (b[i]) b[i] = sample_type'(i * 100);
      push_word(4'd3, b);
      foreach (b[i]) b[i] = sample_type'(1023 - i * 97);
      push_word(4'd3, b);
      for (int k = 0; k < 8; k++) push_word(4'd7, flat_burst(1023));
      for (int k = 0; k < 6; k++) push_word(4'd8, flat_burst(k * 60));
      push_word(4'd10, flat_burst(10'h2AA));
      push_word(4'd11, flat_burst(10'h155));
      drain();

      // long receiver stall while the sender keeps offering, so full rises
      hold_off = 1;
      fork
         random_words(20);
         begin
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
      join
      drain();

      // register settings, extremes included, with random traffic under each
      for (int p = 0; p < 6; p++) begin
         write_reg(REG_FLOOR, floors[p]);
         write_reg(REG_RANGE, ranges[p]);
         push_word(4'd7, flat_burst(1023));
         push_word(4'd0, flat_burst(0));
         random_words(p == 0 ? 700 : 250);
         drain();
      end

      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end
endmodule
